// File: hw/rtl/gcbq_pkg.sv
// Shared types and constants for the grid count box query block.
package gcbq_pkg;

  localparam int FIELD_W     = 3;
  localparam int HIT_COUNT_W = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;
  localparam int QUEUE_DEPTH = 4;

  localparam logic OP_INC   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Classified command passed from the front end to the back end.
  // Query bounds are already clamped to the grid.
  typedef struct packed {
    logic               op;
    logic               empty;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] col_lo;
    logic [FIELD_W-1:0] row_lo;
    logic [FIELD_W-1:0] col_hi;
    logic [FIELD_W-1:0] row_hi;
  } cmd_t;

endpackage

// File: hw/rtl/gcbq_front.sv
// Front end: accepts input beats, clamps query boxes and drops off-grid increments.
module gcbq_front #(
  parameter int GRID_SIDE = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [gcbq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  output logic                             q_push,
  output gcbq_pkg::cmd_t                   q_cmd,
  input  logic                             q_ready
);

  localparam int FW = gcbq_pkg::FIELD_W;
  localparam logic [FW-1:0] MAX_IDX = FW'(GRID_SIDE - 1);

  gcbq_pkg::cmd_t cmd_r, cmd_nxt, dec;
  logic           cmd_v_r, cmd_v_nxt;
  logic           accept, drop;

  function automatic logic [FW-1:0] clamp(input logic [FW-1:0] v);
    clamp = (v > MAX_IDX) ? MAX_IDX : v;
  endfunction

  always_comb begin
    dec.op     = in_tuser;
    dec.row    = in_tdata[FW-1:0];
    dec.col    = in_tdata[2*FW-1:FW];
    dec.col_lo = clamp(in_tdata[3*FW-1:2*FW]);
    dec.row_lo = clamp(in_tdata[4*FW-1:3*FW]);
    dec.col_hi = clamp(in_tdata[5*FW-1:4*FW]);
    dec.row_hi = clamp(in_tdata[6*FW-1:5*FW]);
    dec.empty  = (dec.row_lo > dec.row_hi) || (dec.col_lo > dec.col_hi);
    drop       = (in_tuser == gcbq_pkg::OP_INC) &&
                 ((dec.row > MAX_IDX) || (dec.col > MAX_IDX));
  end

  assign in_tready = !cmd_v_r || q_ready;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = cmd_v_r;
  assign q_cmd     = cmd_r;

  always_comb begin
    cmd_v_nxt = cmd_v_r;
    cmd_nxt   = cmd_r;
    if (cmd_v_r && q_ready) begin
      cmd_v_nxt = 1'b0;
    end
    if (accept && !drop) begin
      cmd_v_nxt = 1'b1;
      cmd_nxt   = dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_v_r <= 1'b0;
    end else begin
      cmd_v_r <= cmd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule

// File: hw/rtl/gcbq_fifo.sv
// Short command queue between the front end and the back end.
module gcbq_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gcbq_pkg::cmd_t push_cmd,
  output logic           ready,
  output logic           head_valid,
  output gcbq_pkg::cmd_t head_cmd,
  input  logic           pop
);

  localparam int DEPTH = gcbq_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  gcbq_pkg::cmd_t   ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign ready      = (cnt_r != FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = ent_r[rd_ptr_r];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/gcbq_back.sv
// Back end: count memory, increment read-modify-write and box walk with output register.
module gcbq_back #(
  parameter int GRID_SIDE   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  gcbq_pkg::cmd_t                   q_cmd,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [gcbq_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);

  localparam int FW     = gcbq_pkg::FIELD_W;
  localparam int HCW    = gcbq_pkg::HIT_COUNT_W;
  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PAD_W  = gcbq_pkg::OUT_TDATA_W - 2 * FW - HCW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_INC   = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [COUNT_WIDTH-1:0] mem [CELLS];
  logic [CELLS-1:0]       vld_r;

  logic [1:0]             st_r, st_nxt;
  logic                   rd_en, wr_en;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      inc_addr_r, inc_addr_nxt;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic                   rd_vld_r;
  logic [COUNT_WIDTH-1:0] cell_cnt;
  logic                   cell_nz;

  logic [FW-1:0]          cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [FW-1:0]          col_lo_r, col_lo_nxt, col_hi_r, col_hi_nxt, row_hi_r, row_hi_nxt;
  logic                   iss_r, iss_nxt;

  logic                   s1_v_r, s1_v_nxt, s1_last_r, s1_last_nxt;
  logic [FW-1:0]          s1_row_r, s1_row_nxt, s1_col_r, s1_col_nxt;

  logic                   pend_v_r, pend_v_nxt;
  logic [FW-1:0]          pend_row_r, pend_row_nxt, pend_col_r, pend_col_nxt;
  logic [COUNT_WIDTH-1:0] pend_cnt_r, pend_cnt_nxt;

  logic                   out_v_r, out_v_nxt, out_found_r, out_found_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [FW-1:0]          out_row_r, out_row_nxt, out_col_r, out_col_nxt;
  logic [HCW-1:0]         out_cnt_r, out_cnt_nxt;

  logic                   out_free, adv;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [FW-1:0] r,
                                                  input logic [FW-1:0] c);
    cell_addr = ADDR_W'(r) * ADDR_W'(GRID_SIDE) + ADDR_W'(c);
  endfunction

  assign cell_cnt = rd_vld_r ? rd_data_r : '0;
  assign cell_nz  = (cell_cnt != '0);
  assign out_free = !out_v_r || out_tready;
  assign adv      = !(s1_v_r && cell_nz && pend_v_r) || out_free;

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_cnt_r, out_col_r, out_row_r};

  always_comb begin
    st_nxt        = st_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = cell_addr(cur_row_r, cur_col_r);
    wr_en         = 1'b0;
    wr_data       = (cell_cnt == '1) ? cell_cnt : cell_cnt + 1'b1;
    inc_addr_nxt  = inc_addr_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    col_lo_nxt    = col_lo_r;
    col_hi_nxt    = col_hi_r;
    row_hi_nxt    = row_hi_r;
    iss_nxt       = iss_r;
    s1_v_nxt      = s1_v_r;
    s1_last_nxt   = s1_last_r;
    s1_row_nxt    = s1_row_r;
    s1_col_nxt    = s1_col_r;
    pend_v_nxt    = pend_v_r;
    pend_row_nxt  = pend_row_r;
    pend_col_nxt  = pend_col_r;
    pend_cnt_nxt  = pend_cnt_r;
    out_v_nxt     = out_v_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_cnt_nxt   = out_cnt_r;

    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.op == gcbq_pkg::OP_INC) begin
            rd_en        = 1'b1;
            rd_addr      = cell_addr(q_cmd.row, q_cmd.col);
            inc_addr_nxt = cell_addr(q_cmd.row, q_cmd.col);
            st_nxt       = ST_INC;
          end else begin
            pend_v_nxt  = 1'b0;
            s1_v_nxt    = 1'b0;
            cur_row_nxt = q_cmd.row_lo;
            cur_col_nxt = q_cmd.col_lo;
            col_lo_nxt  = q_cmd.col_lo;
            col_hi_nxt  = q_cmd.col_hi;
            row_hi_nxt  = q_cmd.row_hi;
            iss_nxt     = 1'b1;
            st_nxt      = q_cmd.empty ? ST_FLUSH : ST_WALK;
          end
        end
      end
      ST_INC: begin
        wr_en  = 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_WALK: begin
        if (adv) begin
          if (s1_v_r) begin
            if (cell_nz) begin
              if (pend_v_r) begin
                out_v_nxt     = 1'b1;
                out_found_nxt = 1'b1;
                out_last_nxt  = 1'b0;
                out_row_nxt   = pend_row_r;
                out_col_nxt   = pend_col_r;
                out_cnt_nxt   = HCW'(pend_cnt_r);
              end
              pend_v_nxt   = 1'b1;
              pend_row_nxt = s1_row_r;
              pend_col_nxt = s1_col_r;
              pend_cnt_nxt = cell_cnt;
            end
            if (s1_last_r) begin
              st_nxt = ST_FLUSH;
            end
          end
          if (iss_r) begin
            rd_en       = 1'b1;
            s1_v_nxt    = 1'b1;
            s1_row_nxt  = cur_row_r;
            s1_col_nxt  = cur_col_r;
            s1_last_nxt = (cur_row_r == row_hi_r) && (cur_col_r == col_hi_r);
            if (cur_col_r == col_hi_r) begin
              cur_col_nxt = col_lo_r;
              if (cur_row_r == row_hi_r) begin
                iss_nxt = 1'b0;
              end else begin
                cur_row_nxt = cur_row_r + 1'b1;
              end
            end else begin
              cur_col_nxt = cur_col_r + 1'b1;
            end
          end else begin
            s1_v_nxt = 1'b0;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_v_nxt     = 1'b1;
          out_last_nxt  = 1'b1;
          out_found_nxt = pend_v_r;
          out_row_nxt   = pend_v_r ? pend_row_r : '0;
          out_col_nxt   = pend_v_r ? pend_col_r : '0;
          out_cnt_nxt   = pend_v_r ? HCW'(pend_cnt_r) : '0;
          pend_v_nxt    = 1'b0;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      vld_r    <= '0;
      iss_r    <= 1'b0;
      s1_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      iss_r    <= iss_nxt;
      s1_v_r   <= s1_v_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      if (wr_en) begin
        vld_r[inc_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    inc_addr_r  <= inc_addr_nxt;
    cur_row_r   <= cur_row_nxt;
    cur_col_r   <= cur_col_nxt;
    col_lo_r    <= col_lo_nxt;
    col_hi_r    <= col_hi_nxt;
    row_hi_r    <= row_hi_nxt;
    s1_last_r   <= s1_last_nxt;
    s1_row_r    <= s1_row_nxt;
    s1_col_r    <= s1_col_nxt;
    pend_row_r  <= pend_row_nxt;
    pend_col_r  <= pend_col_nxt;
    pend_cnt_r  <= pend_cnt_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[inc_addr_r] <= wr_data;
    end
  end

endmodule

// File: hw/rtl/grid_count_box_query.sv
// Top level of the grid count box query block.
// Holds a GRID_SIDE x GRID_SIDE grid of saturating counters, all zero after
// reset (per-cell valid flops, so no clearing pass). in_tuser 0 increments
// the cell at (row, col); off-grid increments are dropped. in_tuser 1
// queries a box: it is walked row-major and one beat goes out per nonzero
// cell, the final one with out_tlast; an empty or hit-free box gives one beat
// with out_tuser clear. Input beats land in a 4-entry command queue. The back
// end reads the count memory once per cycle while it walks a box, holding
// while a found cell waits on out_tready; an increment reads the cell and then
// writes it back. An empty box skips the walk.
module grid_count_box_query #(
  parameter int GRID_SIDE   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // row, col, box_col_low, box_row_low, box_col_high, box_row_high, zero pad
  input  logic [gcbq_pkg::IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // hit_row, hit_col, hit_count, zero pad
  output logic [gcbq_pkg::OUT_TDATA_W-1:0] out_tdata,
  // found
  output logic                             out_tuser,
  output logic                             out_tlast
);

  logic           f_push, f_ready, q_valid, q_pop;
  gcbq_pkg::cmd_t f_cmd, q_cmd;

  gcbq_front #(
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (f_push),
    .q_cmd     (f_cmd),
    .q_ready   (f_ready)
  );

  gcbq_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_push),
    .push_cmd   (f_cmd),
    .ready      (f_ready),
    .head_valid (q_valid),
    .head_cmd   (q_cmd),
    .pop        (q_pop)
  );

  gcbq_back #(
    .GRID_SIDE   (GRID_SIDE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: tb/tb_grid_count_box_query.sv
// Testbench for grid_count_box_query: directed and random increments and box queries.
`timescale 1ns / 100ps

module tb_grid_count_box_query;

  localparam int SIDE         = 8;
  localparam int CYCLE_LIMIT  = 10000000;
  localparam int DRAIN_WAIT   = 100;
  localparam int RANDOM_BEATS = 440;
  localparam int REPEAT_HITS  = 20;
  localparam logic [gcbq_pkg::HIT_COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                             found;
    logic [gcbq_pkg::FIELD_W-1:0]     row;
    logic [gcbq_pkg::FIELD_W-1:0]     col;
    logic [gcbq_pkg::HIT_COUNT_W-1:0] count;
    logic                             last;
  } hit_rec_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [gcbq_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [gcbq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;
  logic                             out_tlast;

  logic [gcbq_pkg::HIT_COUNT_W-1:0] hit_grid [SIDE*SIDE];
  hit_rec_t                         pending_hits [$];
  bit                               quiet;
  int                               ready_hold;
  int                               errors = 0;
  int                               cycles = 0;
  int                               inc_beats;
  int                               query_beats;
  int                               hits_checked = 0;

  grid_count_box_query u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still pending", $time, pending_hits.size());
      $display("grid_count_box_query test failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk) begin
    int pick;
    if (quiet || !rst_n) begin
      out_tready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if (out_tready) begin
      pick = $urandom_range(0, 99);
      out_tready <= 1'b0;
      ready_hold = (pick < 70) ? $urandom_range(0, 2) :
                   (pick < 95) ? $urandom_range(3, 8) : $urandom_range(20, 40);
    end else begin
      out_tready <= 1'b1;
      ready_hold = $urandom_range(0, 12);
    end
  end

  // Model update and result prediction for one accepted input beat.
  task automatic apply_to_grid(input logic op,
                               input logic [gcbq_pkg::IN_TDATA_W-1:0] data);
    int rlo, rhi, clo, chi, idx, n;
    hit_rec_t rec;
    if (op == gcbq_pkg::OP_INC) begin
      idx = data[2:0] * SIDE + data[5:3];
      if (hit_grid[idx] != COUNT_MAX) hit_grid[idx]++;
      inc_beats++;
    end else begin
      clo = (data[8:6]   > SIDE - 1) ? SIDE - 1 : data[8:6];
      rlo = (data[11:9]  > SIDE - 1) ? SIDE - 1 : data[11:9];
      chi = (data[14:12] > SIDE - 1) ? SIDE - 1 : data[14:12];
      rhi = (data[17:15] > SIDE - 1) ? SIDE - 1 : data[17:15];
      n = 0;
      for (int r = rlo; r <= rhi; r++) begin
        for (int c = clo; c <= chi; c++) begin
          if (hit_grid[r*SIDE+c] != 0) begin
            rec.found = 1'b1;
            rec.row   = r[gcbq_pkg::FIELD_W-1:0];
            rec.col   = c[gcbq_pkg::FIELD_W-1:0];
            rec.count = hit_grid[r*SIDE+c];
            rec.last  = 1'b0;
            pending_hits.push_back(rec);
            n++;
          end
        end
      end
      if (n == 0) begin
        rec = '0;
        rec.last = 1'b1;
        pending_hits.push_back(rec);
      end else begin
        pending_hits[pending_hits.size()-1].last = 1'b1;
      end
      query_beats++;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input logic op, input logic [gcbq_pkg::IN_TDATA_W-1:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    apply_to_grid(op, data);
    @(negedge clk);
  endtask

  function automatic logic [gcbq_pkg::IN_TDATA_W-1:0] cell_data(input int row,
                                                                 input int col);
    logic [gcbq_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[2:0] = row[2:0];
    d[5:3] = col[2:0];
    return d;
  endfunction

  function automatic logic [gcbq_pkg::IN_TDATA_W-1:0] box_data(input int clo, input int rlo,
                                                                input int chi, input int rhi);
    logic [gcbq_pkg::IN_TDATA_W-1:0] d;
    d = '0;
    d[8:6]   = clo[2:0];
    d[11:9]  = rlo[2:0];
    d[14:12] = chi[2:0];
    d[17:15] = rhi[2:0];
    return d;
  endfunction

  always @(posedge clk) begin
    hit_rec_t want;
    hit_rec_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.found = out_tuser;
      got.row   = out_tdata[2:0];
      got.col   = out_tdata[5:3];
      got.count = out_tdata[21:6];
      got.last  = out_tlast;
      if (pending_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat found=%0b row=%0d col=%0d count=%0d last=%0b",
                 $time, got.found, got.row, got.col, got.count, got.last);
      end else begin
        want = pending_hits.pop_front();
        hits_checked++;
        if (got.found !== want.found || got.row !== want.row || got.col !== want.col ||
            got.count !== want.count || got.last !== want.last) begin
          errors++;
          $display("%0t: mismatch exp found=%0b row=%0d col=%0d count=%0d last=%0b, %s",
                   $time, want.found, want.row, want.col, want.count, want.last,
                   $sformatf("got found=%0b row=%0d col=%0d count=%0d last=%0b",
                             got.found, got.row, got.col, got.count, got.last));
        end
      end
    end
  end

  task automatic test_empty_grid();
    send_beat(gcbq_pkg::OP_QUERY, box_data(0, 0, 7, 7));
    send_beat(gcbq_pkg::OP_QUERY, box_data(4, 4, 4, 4));
    send_beat(gcbq_pkg::OP_QUERY, box_data(0, 6, 7, 2));
    send_beat(gcbq_pkg::OP_QUERY, box_data(5, 0, 1, 7));
  endtask

  task automatic test_corners_and_boxes();
    send_beat(gcbq_pkg::OP_INC, cell_data(0, 0));
    send_beat(gcbq_pkg::OP_INC, cell_data(7, 7));
    send_beat(gcbq_pkg::OP_INC, cell_data(0, 7));
    send_beat(gcbq_pkg::OP_INC, cell_data(7, 0));
    send_beat(gcbq_pkg::OP_INC, cell_data(7, 7));
    send_beat(gcbq_pkg::OP_INC, cell_data(3, 4));
    send_beat(gcbq_pkg::OP_QUERY, box_data(0, 0, 7, 7));
    send_beat(gcbq_pkg::OP_QUERY, box_data(7, 7, 7, 7));
    send_beat(gcbq_pkg::OP_QUERY, box_data(0, 7, 7, 7));
    send_beat(gcbq_pkg::OP_QUERY, box_data(1, 1, 6, 6));
    send_beat(gcbq_pkg::OP_QUERY, box_data(5, 5, 6, 6));
    send_beat(gcbq_pkg::OP_QUERY, box_data(0, 7, 7, 0));
    send_beat(gcbq_pkg::OP_QUERY, box_data(7, 0, 0, 7));
  endtask

  task automatic test_repeated_hits();
    quiet = 1'b1;
    repeat (REPEAT_HITS) send_beat(gcbq_pkg::OP_INC, cell_data(2, 5));
    send_beat(gcbq_pkg::OP_QUERY, box_data(5, 2, 5, 2));
    quiet = 1'b0;
    send_beat(gcbq_pkg::OP_QUERY, box_data(0, 0, 7, 7));
  endtask

  task automatic test_random_mix();
    logic [gcbq_pkg::IN_TDATA_W-1:0] d;
    int clo, chi, rlo, rhi;
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      quiet = (i >= 200 && i < 260);
      d = '0;
      d[17:0] = 18'($urandom);
      if ($urandom_range(0, 99) < 60) begin
        send_beat(gcbq_pkg::OP_INC, d);
      end else begin
        if ($urandom_range(0, 99) >= 15) begin
          clo = $urandom_range(0, 7);
          chi = $urandom_range(clo, 7);
          rlo = $urandom_range(0, 7);
          rhi = $urandom_range(rlo, 7);
          d[17:6] = 12'(box_data(clo, rlo, chi, rhi) >> 6);
        end
        send_beat(gcbq_pkg::OP_QUERY, d);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = 1'b0;
    in_tdata   = '0;
    quiet      = 1'b0;
    inc_beats  = 0;
    query_beats = 0;
    foreach (hit_grid[i]) hit_grid[i] = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_grid();
    test_corners_and_boxes();
    test_repeated_hits();
    test_random_mix();

    in_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d increments (one cell hit many times) and %0d box queries,",
             inc_beats, query_beats);
    $display("with %0d result beats compared under random gaps and output stalls.",
             hits_checked);
    if (errors == 0) begin
      $display("grid_count_box_query test passed");
    end else begin
      $display("grid_count_box_query test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/gcbq_pkg.sv
hw/rtl/gcbq_front.sv
hw/rtl/gcbq_fifo.sv
hw/rtl/gcbq_back.sv
hw/rtl/grid_count_box_query.sv
tb/tb_grid_count_box_query.sv
